/* rtl/brsc_pkg.sv */
// Package for the barometer raw sample compensation block.
// Word width, pipeline depths, calibration register codes and arithmetic helpers.
// No dependencies.
package brsc_pkg;

    localparam int WORD_W  = 32;
    localparam int DIV_STG = WORD_W;              // one quotient bit per divider stage
    localparam int LAT     = 1 + 3 + DIV_STG + 10 + DIV_STG + 6 + 1;

    // calibration register indexes
    localparam logic [2:0] REG_AC1_AC2 = 3'd0;
    localparam logic [2:0] REG_AC3_AC4 = 3'd1;
    localparam logic [2:0] REG_AC5_AC6 = 3'd2;
    localparam logic [2:0] REG_B1_B2   = 3'd3;
    localparam logic [2:0] REG_MC_MD   = 3'd4;
    localparam logic [2:0] REG_OSS     = 3'd5;

    localparam logic [WORD_W-1:0] K_B6_OFS  = WORD_W'(4000);
    localparam logic [WORD_W-1:0] K_B4_OFS  = WORD_W'(32768);
    localparam logic [WORD_W-1:0] K_B7_SCL  = WORD_W'(50000);
    localparam logic [WORD_W-1:0] K_P_SQ    = WORD_W'(3038);
    localparam logic [WORD_W-1:0] K_P_LIN   = -WORD_W'(7357);
    localparam logic [WORD_W-1:0] K_P_OFS   = WORD_W'(3791);

    typedef logic [WORD_W-1:0] t_word;

    // payload carried down the pipeline; each stage fills in or overwrites some of its fields
    typedef struct packed {
        logic [15:0] ut;
        t_word       up;
        t_word       m1;
        t_word       x1;
        t_word       den;
        t_word       nmag;
        t_word       dmag;
        logic        neg;
        logic        dz;
        t_word       b5;
        t_word       tv;
        t_word       b6;
        t_word       sq;
        t_word       a2;
        t_word       a3;
        t_word       xa;
        t_word       xc;
        t_word       x3;
        t_word       x3b;
        t_word       b3;
        t_word       b4;
        t_word       dd;
        t_word       b7;
        logic        big;
        logic        bz;
        t_word       p;
        t_word       ps;
        t_word       pm;
        t_word       psq;
        t_word       x2p;
        t_word       x1m;
        t_word       s;
        t_word       pf;
    } t_ctx;

    // low word of a product (wrapping multiply)
    function automatic t_word mul_lo(input t_word a, input t_word b);
        logic [2*WORD_W-1:0] t;
        t = {{WORD_W{1'b0}}, a} * {{WORD_W{1'b0}}, b};
        return t[WORD_W-1:0];
    endfunction

    function automatic t_word asr(input t_word a, input int unsigned n);
        return t_word'($signed(a) >>> n);
    endfunction

    function automatic t_word sx16(input logic [15:0] v);
        return {{(WORD_W-16){v[15]}}, v};
    endfunction

    function automatic t_word zx16(input logic [15:0] v);
        return {{(WORD_W-16){1'b0}}, v};
    endfunction

endpackage

/* rtl/brsc_if.sv */
// Handshake channel interfaces for the compensation block.
// No dependencies.
interface brsc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] raw_temperature;
    logic [23:0] raw_pressure;
    modport source (output valid, raw_temperature, raw_pressure, input ready);
    modport sink   (input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface brsc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] temperature_tenths;
    logic [23:0] pressure_pa;
    logic        divide_error;
    logic        saturated;
    modport source (output valid, temperature_tenths, pressure_pa, divide_error, saturated,
                    input ready);
    modport sink   (input valid, temperature_tenths, pressure_pa, divide_error, saturated,
                    output ready);
endinterface

interface brsc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/barometer_raw_sample_compensation.sv */
// Top level of the barometer raw sample compensation block.
// Depends on brsc_pkg, brsc_if and brsc_div.
//
// Takes one raw temperature / pressure sample pair per cycle while the output
// is not stalled and returns the compensated temperature (0.1 degC) and
// pressure (Pa). The pipeline is built around two 32-stage pipelined dividers
// (temperature correction and pressure scaling). The whole pipeline advances
// whenever the output register is empty or being taken, so a stalled consumer
// freezes it without loss. Calibration writes are taken whenever reset is
// released and must only happen while no sample is in flight.
module barometer_raw_sample_compensation
    import brsc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    brsc_in_if.sink       i_smp,
    brsc_cfg_if.sink      i_cfg,
    brsc_out_if.source    o_res
);

    // calibration registers
    logic [31:0] r_cal [5];
    logic [1:0]  r_oss;

    logic [15:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign {ac1, ac2} = r_cal[REG_AC1_AC2];
    assign {ac3, ac4} = r_cal[REG_AC3_AC4];
    assign {ac5, ac6} = r_cal[REG_AC5_AC6];
    assign {b1, b2}   = r_cal[REG_B1_B2];
    assign {mc, md}   = r_cal[REG_MC_MD];

    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 5; k++) r_cal[k] <= '0;
            r_oss <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_AC1_AC2: r_cal[REG_AC1_AC2] <= i_cfg.data;
                REG_AC3_AC4: r_cal[REG_AC3_AC4] <= i_cfg.data;
                REG_AC5_AC6: r_cal[REG_AC5_AC6] <= i_cfg.data;
                REG_B1_B2:   r_cal[REG_B1_B2]   <= i_cfg.data;
                REG_MC_MD:   r_cal[REG_MC_MD]   <= i_cfg.data;
                REG_OSS:     r_oss              <= i_cfg.data[1:0];
                default: ;
            endcase
        end
    end

    // global advance: output register free or being drained
    logic en;
    logic [LAT-1:0] r_vld;
    assign en          = !r_vld[LAT-1] || o_res.ready;
    assign i_smp.ready = en && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_smp.valid};
        end
    end

    // stage registers
    t_ctx r_s0, r_s1, r_s2, r_s3, r_s4, r_s5, r_s6, r_s7, r_s8, r_s9;
    t_ctx r_s10, r_s11, r_s12, r_s13, r_s14, r_s15, r_s16, r_s17, r_s18, r_s19;
    t_ctx n_s0, n_s1, n_s2, n_s3, n_s4, n_s5, n_s6, n_s7, n_s8, n_s9;
    t_ctx n_s10, n_s11, n_s12, n_s13, n_s14, n_s15, n_s16, n_s17, n_s18, n_s19;
    t_ctx r_d1 [DIV_STG];
    t_ctx r_d2 [DIV_STG];
    t_word q1, q2;

    // input capture and oversampling shift
    always_comb begin
        n_s0    = '0;
        n_s0.ut = i_smp.raw_temperature;
        n_s0.up = WORD_W'(i_smp.raw_pressure >> (4'd8 - {2'b00, r_oss}));
    end

    // (UT - AC6) * AC5
    always_comb begin
        n_s1    = r_s0;
        n_s1.m1 = mul_lo(zx16(r_s0.ut) - zx16(ac6), zx16(ac5));
    end

    // X1 and the temperature divisor
    always_comb begin
        n_s2     = r_s1;
        n_s2.x1  = asr(r_s1.m1, 15);
        n_s2.den = asr(r_s1.m1, 15) + sx16(md);
    end

    // sign and magnitude split for the divider
    always_comb begin
        t_word num;
        num       = sx16(mc) << 11;
        n_s3      = r_s2;
        n_s3.nmag = num[WORD_W-1] ? -num : num;
        n_s3.dmag = r_s2.den[WORD_W-1] ? -r_s2.den : r_s2.den;
        n_s3.neg  = num[WORD_W-1] ^ r_s2.den[WORD_W-1];
        n_s3.dz   = (r_s2.den == '0);
    end

    brsc_div u_div_t (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (r_s3.nmag),
        .i_divisor  (r_s3.dmag),
        .o_quotient (q1)
    );

    // B5 = X1 + X2
    always_comb begin
        n_s4    = r_d1[DIV_STG-1];
        n_s4.b5 = r_d1[DIV_STG-1].x1 + (r_d1[DIV_STG-1].neg ? -q1 : q1);
    end

    // temperature result and B6
    always_comb begin
        n_s5    = r_s4;
        n_s5.tv = asr(r_s4.b5 + WORD_W'(8), 4);
        n_s5.b6 = r_s4.b5 - K_B6_OFS;
    end

    // B6 products
    always_comb begin
        n_s6    = r_s5;
        n_s6.sq = mul_lo(r_s5.b6, r_s5.b6);
        n_s6.a2 = mul_lo(sx16(ac2), r_s5.b6);
        n_s6.a3 = mul_lo(sx16(ac3), r_s5.b6);
    end

    always_comb begin
        n_s7    = r_s6;
        n_s7.sq = asr(r_s6.sq, 12);
        n_s7.xa = asr(r_s6.a2, 11);
        n_s7.xc = asr(r_s6.a3, 13);
    end

    // quadratic coefficient products
    always_comb begin
        n_s8    = r_s7;
        n_s8.a2 = mul_lo(sx16(b2), r_s7.sq);
        n_s8.a3 = mul_lo(sx16(b1), r_s7.sq);
    end

    always_comb begin
        n_s9     = r_s8;
        n_s9.x3  = asr(r_s8.a2, 11) + r_s8.xa;
        n_s9.x3b = asr(r_s8.xc + asr(r_s8.a3, 16) + WORD_W'(2), 2);
    end

    // B3 and AC4 operand
    always_comb begin
        n_s10     = r_s9;
        n_s10.b3  = asr((((sx16(ac1) << 2) + r_s9.x3) << r_oss) + WORD_W'(2), 2);
        n_s10.x3b = r_s9.x3b + K_B4_OFS;
    end

    // B4 and UP - B3
    always_comb begin
        n_s11    = r_s10;
        n_s11.b4 = mul_lo(zx16(ac4), r_s10.x3b) >> 15;
        n_s11.dd = r_s10.up - r_s10.b3;
    end

    always_comb begin
        n_s12    = r_s11;
        n_s12.b7 = mul_lo(r_s11.dd, K_B7_SCL >> r_oss);
        n_s12.bz = (r_s11.b4 == '0);
    end

    // pick doubling before or after the divide
    always_comb begin
        n_s13     = r_s12;
        n_s13.big = r_s12.b7[WORD_W-1];
        n_s13.dd  = r_s12.b7[WORD_W-1] ? r_s12.b7 : (r_s12.b7 << 1);
    end

    brsc_div u_div_p (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (r_s13.dd),
        .i_divisor  (r_s13.b4),
        .o_quotient (q2)
    );

    always_comb begin
        n_s14   = r_d2[DIV_STG-1];
        n_s14.p = r_d2[DIV_STG-1].big ? (q2 << 1) : q2;
    end

    always_comb begin
        n_s15    = r_s14;
        n_s15.ps = asr(r_s14.p, 8);
        n_s15.pm = mul_lo(K_P_LIN, r_s14.p);
    end

    always_comb begin
        n_s16     = r_s15;
        n_s16.psq = mul_lo(r_s15.ps, r_s15.ps);
        n_s16.x2p = asr(r_s15.pm, 16);
    end

    always_comb begin
        n_s17     = r_s16;
        n_s17.x1m = mul_lo(r_s16.psq, K_P_SQ);
    end

    always_comb begin
        n_s18   = r_s17;
        n_s18.s = asr(r_s17.x1m, 16) + r_s17.x2p + K_P_OFS;
    end

    always_comb begin
        n_s19    = r_s18;
        n_s19.pf = r_s18.p + asr(r_s18.s, 4);
    end

    // saturation and error masking
    logic [15:0] n_t;
    logic [23:0] n_p;
    logic        n_err, n_sat, sat_t, sat_p;
    always_comb begin
        sat_t = 1'b0;
        sat_p = 1'b0;
        n_t   = r_s19.tv[15:0];
        n_p   = r_s19.pf[23:0];
        if ($signed(r_s19.tv) > $signed(WORD_W'(32767))) begin
            n_t = 16'h7FFF; sat_t = 1'b1;
        end else if ($signed(r_s19.tv) < $signed(-WORD_W'(32768))) begin
            n_t = 16'h8000; sat_t = 1'b1;
        end
        if ($signed(r_s19.pf) > $signed(WORD_W'(8388607))) begin
            n_p = 24'h7FFFFF; sat_p = 1'b1;
        end else if ($signed(r_s19.pf) < $signed(-WORD_W'(8388608))) begin
            n_p = 24'h800000; sat_p = 1'b1;
        end
        n_err = r_s19.dz || r_s19.bz;
        n_sat = (sat_t || sat_p) && !n_err;
        if (n_err) begin
            n_t = '0;
            n_p = '0;
        end
    end

    logic [15:0] r_t;
    logic [23:0] r_p;
    logic        r_err, r_sat;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0  <= n_s0;  r_s1  <= n_s1;  r_s2  <= n_s2;  r_s3  <= n_s3;
            r_s4  <= n_s4;  r_s5  <= n_s5;  r_s6  <= n_s6;  r_s7  <= n_s7;
            r_s8  <= n_s8;  r_s9  <= n_s9;  r_s10 <= n_s10; r_s11 <= n_s11;
            r_s12 <= n_s12; r_s13 <= n_s13; r_s14 <= n_s14; r_s15 <= n_s15;
            r_s16 <= n_s16; r_s17 <= n_s17; r_s18 <= n_s18; r_s19 <= n_s19;
            r_d1[0] <= r_s3;
            r_d2[0] <= r_s13;
            for (int k = 1; k < DIV_STG; k++) begin
                r_d1[k] <= r_d1[k-1];
                r_d2[k] <= r_d2[k-1];
            end
            r_t   <= n_t;
            r_p   <= n_p;
            r_err <= n_err;
            r_sat <= n_sat;
        end
    end

    assign o_res.valid              = r_vld[LAT-1];
    assign o_res.temperature_tenths = r_t;
    assign o_res.pressure_pa        = r_p;
    assign o_res.divide_error       = r_err;
    assign o_res.saturated          = r_sat;

endmodule

/* rtl/brsc_div.sv */
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on brsc_pkg. Every stage is registered and advances only while i_en is high.
module brsc_div
    import brsc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_word i_dividend,
    input  t_word i_divisor,
    output t_word o_quotient
);

    t_word r_rem [DIV_STG];
    t_word r_num [DIV_STG];
    t_word r_quo [DIV_STG];
    t_word r_dvs [DIV_STG];

    genvar g;
    generate
        for (g = 0; g < DIV_STG; g++) begin : g_stg
            t_word            rem_in, num_in, quo_in, dvs_in;
            logic [WORD_W:0]  trial;
            t_word            n_rem, n_quo;

            if (g == 0) begin : g_first
                assign rem_in = '0;
                assign num_in = i_dividend;
                assign quo_in = '0;
                assign dvs_in = i_divisor;
            end else begin : g_next
                assign rem_in = r_rem[g-1];
                assign num_in = r_num[g-1];
                assign quo_in = r_quo[g-1];
                assign dvs_in = r_dvs[g-1];
            end

            // shift in next dividend bit, subtract when it fits
            always_comb begin
                trial = {rem_in, num_in[WORD_W-1]};
                if (trial >= {1'b0, dvs_in}) begin
                    n_rem = WORD_W'(trial - {1'b0, dvs_in});
                    n_quo = {quo_in[WORD_W-2:0], 1'b1};
                end else begin
                    n_rem = trial[WORD_W-1:0];
                    n_quo = {quo_in[WORD_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g] <= n_rem;
                    r_num[g] <= {num_in[WORD_W-2:0], 1'b0};
                    r_quo[g] <= n_quo;
                    r_dvs[g] <= dvs_in;
                end
            end
        end
    endgenerate

    assign o_quotient = r_quo[DIV_STG-1];

endmodule

/* rtl/brsc_chk.sv */
// Port-level checker for the compensation block, bound to the top level.
// Depends on nothing but the top level's port signals.
module brsc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_t,
    input logic [23:0] i_p,
    input logic        i_err,
    input logic        i_sat
);

    // no result right out of reset
    a_rst_clear: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a waiting result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable({i_t, i_p, i_err, i_sat}))
        else $error("result changed while stalled");

    // divide error zeroes every result field
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_err |-> i_t == '0 && i_p == '0 && !i_sat)
        else $error("divide error with nonzero fields");

    // a clipped result sits at a range limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_sat |-> i_t == 16'h7FFF || i_t == 16'h8000
                                 || i_p == 24'h7FFFFF || i_p == 24'h800000)
        else $error("saturated flag without a clipped field");

endmodule

bind barometer_raw_sample_compensation brsc_chk u_brsc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_t         (o_res.temperature_tenths),
    .i_p         (o_res.pressure_pa),
    .i_err       (o_res.divide_error),
    .i_sat       (o_res.saturated)
);

/* verif/barometer_raw_sample_compensation_tb.sv */
// Testbench for barometer_raw_sample_compensation: drives sample pairs and calibration
// writes, predicts each compensated result and checks it field by field.
// Depends on brsc_pkg, brsc_if and the block's RTL.
module barometer_raw_sample_compensation_tb;
    import brsc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [15:0] temp;
        logic [23:0] pres;
        logic        dz;
        logic        sat;
    } comp_result_t;

    logic i_clk;
    logic i_rst_n;

    brsc_in_if  smp ();
    brsc_cfg_if cfg ();
    brsc_out_if res ();

    barometer_raw_sample_compensation u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // calibration shadow used by the predictor
    logic [31:0]  cal_regs [0:4];
    logic [1:0]   oss_reg;
    comp_result_t pending_results [$];
    int           err_cnt;
    int           n_samples;
    int           n_results;
    int           n_div_err;
    int           n_sat;
    int           n_cfg;
    int           stall_left;
    int           quiet_left;

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic t_word sra(input t_word a, input int n);
        return t_word'($signed(a) >>> n);
    endfunction

    // signed truncating divide; most negative / -1 wraps
    function automatic t_word div_trunc(input t_word a, input t_word b);
        t_word ma, mb, q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q  = ma / mb;
        return (a[31] ^ b[31]) ? -q : q;
    endfunction

    function automatic logic [31:0] clamp_word(input t_word v, input int bits,
                                               inout logic flag);
        longint maxv, sv;
        maxv = (longint'(1) << (bits - 1)) - 1;
        sv   = longint'($signed(v));
        if (sv > maxv) begin
            flag = 1'b1;
            sv   = maxv;
        end else if (sv < -maxv - 1) begin
            flag = 1'b1;
            sv   = -maxv - 1;
        end
        return 32'(sv);
    endfunction

    // full integer calibration chain on the current calibration
    function automatic comp_result_t compensate_sample(input logic [15:0] ut_raw,
                                                       input logic [23:0] up_raw);
        comp_result_t r;
        t_word ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        t_word ut, up, x1, x2, x3, b3, b4, b5, b6, b7, sq, p, tv, den;
        logic  fl;
        ac1 = {{16{cal_regs[0][31]}}, cal_regs[0][31:16]};
        ac2 = {{16{cal_regs[0][15]}}, cal_regs[0][15:0]};
        ac3 = {{16{cal_regs[1][31]}}, cal_regs[1][31:16]};
        ac4 = {16'd0, cal_regs[1][15:0]};
        ac5 = {16'd0, cal_regs[2][31:16]};
        ac6 = {16'd0, cal_regs[2][15:0]};
        b1  = {{16{cal_regs[3][31]}}, cal_regs[3][31:16]};
        b2  = {{16{cal_regs[3][15]}}, cal_regs[3][15:0]};
        mc  = {{16{cal_regs[4][31]}}, cal_regs[4][31:16]};
        md  = {{16{cal_regs[4][15]}}, cal_regs[4][15:0]};
        ut  = {16'd0, ut_raw};
        up  = {8'd0, up_raw} >> (8 - oss_reg);
        r   = '{temp: '0, pres: '0, dz: 1'b0, sat: 1'b0};
        fl  = 1'b0;

        // temperature
        x1  = sra((ut - ac6) * ac5, 15);
        den = x1 + md;
        if (den == '0) begin
            r.dz = 1'b1;
            return r;
        end
        x2 = div_trunc(mc << 11, den);
        b5 = x1 + x2;
        tv = sra(b5 + 32'd8, 4);

        // pressure scale and offset
        b6 = b5 - 32'd4000;
        sq = sra(b6 * b6, 12);
        x1 = sra(b2 * sq, 11);
        x2 = sra(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = sra(((ac1 * 32'd4 + x3) << oss_reg) + 32'd2, 2);
        x1 = sra(ac3 * b6, 13);
        x2 = sra(b1 * sq, 16);
        x3 = sra(x1 + x2 + 32'd2, 2);
        b4 = (ac4 * (x3 + 32'd32768)) >> 15;
        if (b4 == '0) begin
            r.dz = 1'b1;
            return r;
        end
        b7 = (up - b3) * (32'd50000 >> oss_reg);
        p  = b7[31] ? (b7 / b4) * 32'd2 : (b7 * 32'd2) / b4;

        // second order pressure correction
        x1 = sra(p, 8);
        x1 = x1 * x1;
        x1 = sra(x1 * 32'd3038, 16);
        x2 = sra(-32'd7357 * p, 16);
        p  = p + sra(x1 + x2 + 32'd3791, 4);

        r.temp = 16'(clamp_word(tv, 16, fl));
        r.pres = 24'(clamp_word(p, 24, fl));
        r.sat  = fl;
        return r;
    endfunction

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // send one sample request and record its expected result
    task automatic send_sample(input logic [15:0] ut, input logic [23:0] up);
        int gap;
        smp.valid           <= 1'b1;
        smp.raw_temperature <= ut;
        smp.raw_pressure    <= up;
        do @(posedge i_clk); while (!smp.ready);
        pending_results.push_back(compensate_sample(ut, up));
        n_samples++;
        gap = rand_gap();
        if (gap > 0) begin
            smp.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // calibration write, only once the pipeline has drained
    task automatic write_cal(input logic [2:0] idx, input logic [31:0] val);
        smp.valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (LAT + 4) @(posedge i_clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do @(posedge i_clk); while (!cfg.ready);
        if (idx < REG_OSS) cal_regs[idx] = val;
        else if (idx == REG_OSS) oss_reg = val[1:0];
        n_cfg++;
        cfg.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_cal(input logic [31:0] r0, input logic [31:0] r1,
                            input logic [31:0] r2, input logic [31:0] r3,
                            input logic [31:0] r4, input logic [1:0] oss);
        write_cal(REG_AC1_AC2, r0);
        write_cal(REG_AC3_AC4, r1);
        write_cal(REG_AC5_AC6, r2);
        write_cal(REG_B1_B2, r3);
        write_cal(REG_MC_MD, r4);
        write_cal(REG_OSS, {30'd0, oss});
    endtask

    // typical factory calibration
    task automatic load_typical(input logic [1:0] oss);
        load_cal({16'd408, -16'sd72}, {-16'sd14383, 16'd32741}, {16'd32757, 16'd23153},
                 {16'd6190, 16'd4}, {-16'sd8711, 16'd2868}, oss);
    endtask

    // all-zero calibration after reset: temperature divisor is zero
    task automatic test_reset_state();
        send_sample(16'd27898, 24'h5D2300);
        send_sample(16'hFFFF, 24'hFFFFFF);
        send_sample(16'h0000, 24'h000000);
    endtask

    // field extremes at every oversampling setting
    task automatic test_typical_extremes();
        for (int o = 0; o < 4; o++) begin
            load_typical(2'(o));
            send_sample(16'd27898, 24'(23843 << 8));
            send_sample(16'h0000, 24'h000000);
            send_sample(16'hFFFF, 24'hFFFFFF);
            send_sample(16'h8000, 24'h800000);
            send_sample(16'h7FFF, 24'h7FFFFF);
        end
    endtask

    // zero pressure divisor, divisor of minus one, saturating coefficients
    task automatic test_special_cases();
        load_cal({16'd408, -16'sd72}, {-16'sd14383, 16'd0}, {16'd32757, 16'd23153},
                 {16'd6190, 16'd4}, {-16'sd8711, 16'd2868}, 2'd0);
        send_sample(16'd27898, 24'h5D2300);
        load_cal(32'h0, 32'h0000FFFF, 32'h0, 32'h0, {16'h8000, 16'hFFFF}, 2'd3);
        send_sample(16'd100, 24'h123456);
        send_sample(16'hFFFF, 24'hFFFFFF);
        load_cal(32'h7FFF7FFF, 32'h8000FFFF, 32'hFFFF0000, 32'h7FFF7FFF, 32'h7FFF0001, 2'd1);
        send_sample(16'hFFFF, 24'h000000);
        send_sample(16'h0000, 24'hFFFFFF);
        load_cal(32'h80008000, 32'h7FFF0001, 32'hFFFFFFFF, 32'h80008000, 32'h80007FFF, 2'd2);
        send_sample(16'h0000, 24'h000000);
        send_sample(16'hFFFF, 24'hFFFFFF);
        // unused register indexes are ignored
        write_cal(3'd6, 32'hFFFFFFFF);
        write_cal(3'd7, 32'h12345678);
        send_sample(16'h1234, 24'hABCDEF);
    endtask

    // random calibration sets, mostly near typical values, with random samples
    task automatic test_random(input int n_items);
        int left, burst;
        logic [15:0] t0;
        logic [23:0] p0;
        left = n_items;
        while (left > 0) begin
            if ($urandom_range(0, 2) != 0) begin
                load_cal({16'(408 + $urandom_range(0, 4000) - 2000),
                          16'(-72 + $urandom_range(0, 400) - 200)},
                         {16'(-14383 + $urandom_range(0, 4000) - 2000),
                          16'(30000 + $urandom_range(0, 5000))},
                         {16'(24000 + $urandom_range(0, 9000)),
                          16'(18000 + $urandom_range(0, 10000))},
                         {16'(6190 + $urandom_range(0, 400) - 200),
                          16'($urandom_range(0, 60))},
                         {16'(-8711 + $urandom_range(0, 2000) - 1000),
                          16'(2000 + $urandom_range(0, 1500))},
                         2'($urandom_range(0, 3)));
            end else begin
                load_cal($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                         2'($urandom_range(0, 3)));
            end
            burst = (left < 150) ? left : 150;
            for (int k = 0; k < burst; k++) begin
                if ($urandom_range(0, 3) != 0) begin
                    t0 = 16'($urandom_range(20000, 36000));
                    p0 = 24'($urandom_range(4000000, 16777215));
                end else begin
                    t0 = 16'($urandom());
                    p0 = 24'($urandom());
                end
                send_sample(t0, p0);
            end
            left -= burst;
        end
    endtask

    // result sink with random back-pressure and stall-free stretches
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res.ready <= 1'b0;
        end else if (quiet_left > 0) begin
            quiet_left--;
            res.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            res.ready <= 1'b0;
        end else if ($urandom_range(0, 99) < 3) begin
            quiet_left = $urandom_range(50, 200);
            res.ready <= 1'b1;
        end else begin
            stall_left = rand_gap();
            res.ready <= (stall_left == 0);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        comp_result_t e;
        if (i_rst_n && res.valid && res.ready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding");
                err_cnt++;
            end else begin
                e = pending_results.pop_front();
                if (e.dz) n_div_err++;
                if (e.sat) n_sat++;
                if (res.temperature_tenths !== e.temp) begin
                    $error("temperature_tenths expected %0d got %0d",
                           $signed(e.temp), $signed(res.temperature_tenths));
                    err_cnt++;
                end
                if (res.pressure_pa !== e.pres) begin
                    $error("pressure_pa expected %0d got %0d",
                           $signed(e.pres), $signed(res.pressure_pa));
                    err_cnt++;
                end
                if (res.divide_error !== e.dz) begin
                    $error("divide_error expected %0b got %0b", e.dz, res.divide_error);
                    err_cnt++;
                end
                if (res.saturated !== e.sat) begin
                    $error("saturated expected %0b got %0b", e.sat, res.saturated);
                    err_cnt++;
                end
            end
        end
    end

    // sequence
    initial begin
        err_cnt    = 0;
        n_samples  = 0;
        n_results  = 0;
        n_div_err  = 0;
        n_sat      = 0;
        n_cfg      = 0;
        stall_left = 0;
        quiet_left = 0;
        for (int i = 0; i < 5; i++) cal_regs[i] = '0;
        oss_reg = '0;
        i_rst_n             <= 1'b0;
        smp.valid           <= 1'b0;
        smp.raw_temperature <= '0;
        smp.raw_pressure    <= '0;
        cfg.valid           <= 1'b0;
        cfg.index           <= '0;
        cfg.data            <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_typical_extremes();
        test_special_cases();
        test_random(1620);

        smp.valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (LAT + 20) @(posedge i_clk);
        $display("Sent %0d sample pairs over %0d calibration writes; %0d results checked",
                 n_samples, n_cfg, n_results);
        $display("Divide errors seen: %0d, saturated results: %0d", n_div_err, n_sat);
        if (err_cnt == 0 && pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("Timed out with %0d results outstanding", pending_results.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
rtl/brsc_pkg.sv
rtl/brsc_if.sv
rtl/brsc_div.sv
rtl/barometer_raw_sample_compensation.sv
rtl/brsc_chk.sv
verif/barometer_raw_sample_compensation_tb.sv
